// ----- hdl/robin_hood_hash_table_assert.svh -----
// Assertion macros for the hash table checks.
`ifndef ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RHT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

// ----- hdl/rht_pkg.sv -----
package rht_pkg;

    localparam int DIST_W   = 7;
    localparam int CFG_W    = 11;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;

    localparam logic [CFG_W-1:0] MAX_FILL_RESET = 11'd870;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd7;

    // slot store write kinds
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_VALUE = 3'd1;
    localparam logic [2:0] WR_CARRY = 3'd2;
    localparam logic [2:0] WR_SHIFT = 3'd3;
    localparam logic [2:0] WR_FREE  = 3'd4;
    localparam logic [2:0] WR_SWEEP = 3'd5;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    // result slot / value source
    localparam logic [1:0] SRC_ZERO    = 2'd0;
    localparam logic [1:0] SRC_HIT_OLD = 2'd1;
    localparam logic [1:0] SRC_HIT_NEW = 2'd2;
    localparam logic [1:0] SRC_INSERT  = 2'd3;

    typedef struct packed {
        logic                load;
        logic                start;
        logic                advance;
        logic                rebase;
        logic                take;
        logic [2:0]          wr;
        logic [1:0]          cnt;
        logic                res_en;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_src;
        logic                emit;
    } rht_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              used;
        logic              match;
        logic              d_gt;
        logic              d_gt_max;
        logic              dist_zero;
        logic              step_last;
        logic              full;
        logic              out_busy;
    } rht_stat_t;

endpackage

// ----- hdl/robin_hood_hash_table.sv -----
// Robin Hood hash table with backward-shift removal.
// Request channel (in_valid/in_ready): kind, key_hash, key, value. One request is
// in flight at a time; in_ready is high only while the sequencer is idle.
// Result channel (out_valid/out_ready): status, slot_index, read_value, entries.
// The result sits in an output register, so the next request is taken while it
// waits; a result that cannot leave because the previous one is stalled holds
// the sequencer until the output register frees up.
// Steps: the request is registered, the chain is probed slot by slot, the result is
// held in S_FIN until the output register is free, and in_ready returns in the same
// cycle as out_valid. Find/present walk the chain once; a new insert walks it three
// times (search, range check, commit); remove walks to the hit and then shifts each
// following entry back. The slot store has a single read port: one slot per cycle.
// Clear marks one slot empty per cycle.
// After reset the same sweep runs over every slot with in_ready low; the
// APB port takes max_fill writes throughout. SLOTS must be a power of two.
`include "robin_hood_hash_table_assert.svh"

module robin_hood_hash_table
    import rht_pkg::*;
#(
    parameter int SLOTS        = 1024,
    parameter int KEY_BITS     = 64,
    parameter int VALUE_BITS   = 32,
    parameter int MAX_DISTANCE = 127
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // APB config
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // request
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [KIND_W-1:0]          kind,
    input  logic [31:0]                key_hash,
    input  logic [KEY_BITS-1:0]        key,
    input  logic [VALUE_BITS-1:0]      value,
    // result
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic [$clog2(SLOTS)-1:0]   slot_index,
    output logic [VALUE_BITS-1:0]      read_value,
    output logic [$clog2(SLOTS):0]     entries
);

    localparam int IDX_W = $clog2(SLOTS);

    rht_cmd_t         cmd;
    rht_stat_t        stat;
    logic [CFG_W-1:0] max_fill_reg;

    // register 0 (max_fill) at byte 0; paddr[2] selects the register slot
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - CFG_W){1'b0}}, max_fill_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fill_reg <= MAX_FILL_RESET;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            max_fill_reg <= pwdata[CFG_W-1:0];
        end
    end

    rht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rht_dp #(
        .SLOTS        (SLOTS),
        .KEY_BITS     (KEY_BITS),
        .VALUE_BITS   (VALUE_BITS),
        .MAX_DISTANCE (MAX_DISTANCE),
        .IDX_W        (IDX_W),
        .CNT_W        (IDX_W + 1)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .key_hash   (key_hash),
        .key        (key),
        .value      (value),
        .max_fill   (max_fill_reg),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .slot_index (slot_index),
        .read_value (read_value),
        .entries    (entries)
    );

    // one request at a time: a transfer drops in_ready for the next cycle
    `RHT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // a cleared table reports no entries
    `RHT_ASSERT_NOW(a_clear_empty, out_valid && status == ST_CLEARED, entries == '0)
    // miss and refusal carry zero slot and value
    `RHT_ASSERT_NOW(a_miss_zero,
        out_valid && (status == ST_NOT_FOUND || status == ST_FULL),
        slot_index == '0 && read_value == '0)
    // count never passes the slot total
    `RHT_ASSERT_NOW(a_count_bound, out_valid, entries <= (IDX_W + 1)'(SLOTS))

endmodule

// ----- hdl/rht_ctrl.sv -----
module rht_ctrl
    import rht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] kind,
    output logic              in_ready,
    input  rht_stat_t         stat,
    output rht_cmd_t          cmd
);

    localparam logic [2:0] S_RST  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_LOOK = 3'd3;
    localparam logic [2:0] S_FIT  = 3'd4;
    localparam logic [2:0] S_INS  = 3'd5;
    localparam logic [2:0] S_REM  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_RST:
            begin
                cmd.wr      = WR_SWEEP;
                cmd.advance = 1'b1;
                if (stat.step_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    cmd.start = 1'b1;
                    case (kind)
                        KIND_INSERT, KIND_REPLACE, KIND_FIND, KIND_REMOVE:
                        begin
                            state_next = S_LOOK;
                        end
                        KIND_CLEAR:
                        begin
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_NOT_FOUND;
                            cmd.res_src    = SRC_ZERO;
                            state_next     = S_FIN;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.wr      = WR_SWEEP;
                cmd.advance = 1'b1;
                if (stat.step_last)
                begin
                    cmd.cnt        = CNT_CLR;
                    cmd.res_en     = 1'b1;
                    cmd.res_status = ST_CLEARED;
                    cmd.res_src    = SRC_ZERO;
                    state_next     = S_FIN;
                end
            end
            S_LOOK:
            begin
                if (!stat.used || stat.d_gt || (!stat.match && stat.step_last))
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_src = SRC_ZERO;
                    state_next  = S_FIN;
                    if (stat.kind == KIND_INSERT || stat.kind == KIND_REPLACE)
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.res_en = 1'b0;
                            cmd.start  = 1'b1;
                            state_next = S_FIT;
                        end
                    end
                    else
                    begin
                        cmd.res_status = ST_NOT_FOUND;
                    end
                end
                else if (stat.match)
                begin
                    cmd.res_en = 1'b1;
                    state_next = S_FIN;
                    case (stat.kind)
                        KIND_INSERT:
                        begin
                            cmd.res_status = ST_PRESENT;
                            cmd.res_src    = SRC_HIT_OLD;
                        end
                        KIND_REPLACE:
                        begin
                            cmd.wr         = WR_VALUE;
                            cmd.res_status = ST_REPLACED;
                            cmd.res_src    = SRC_HIT_NEW;
                        end
                        KIND_FIND:
                        begin
                            cmd.res_status = ST_FOUND;
                            cmd.res_src    = SRC_HIT_OLD;
                        end
                        default:
                        begin
                            cmd.res_status = ST_REMOVED;
                            cmd.res_src    = SRC_HIT_OLD;
                            cmd.advance    = 1'b1;
                            state_next     = S_REM;
                        end
                    endcase
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_FIT:
            begin
                // dry run: would the displacement chain stay within range
                if (!stat.used)
                begin
                    if (stat.d_gt_max)
                    begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = ST_FULL;
                        cmd.res_src    = SRC_ZERO;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_INS;
                    end
                end
                else if ((stat.d_gt && stat.d_gt_max) || stat.step_last)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = ST_FULL;
                    cmd.res_src    = SRC_ZERO;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.rebase  = stat.d_gt;
                end
            end
            S_INS:
            begin
                if (!stat.used)
                begin
                    cmd.wr         = WR_CARRY;
                    cmd.cnt        = CNT_INC;
                    cmd.res_en     = 1'b1;
                    cmd.res_status = ST_INSERTED;
                    cmd.res_src    = SRC_INSERT;
                    state_next     = S_FIN;
                end
                else if (stat.d_gt)
                begin
                    cmd.wr      = WR_CARRY;
                    cmd.take    = 1'b1;
                    cmd.rebase  = 1'b1;
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_REM:
            begin
                if (!stat.used || stat.dist_zero)
                begin
                    cmd.wr     = WR_FREE;
                    cmd.cnt    = CNT_DEC;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.wr      = WR_SHIFT;
                    cmd.advance = 1'b1;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_RST;
            end
        endcase
    end

endmodule

// ----- hdl/rht_dp.sv -----
module rht_dp
    import rht_pkg::*;
#(
    parameter int SLOTS        = 1024,
    parameter int KEY_BITS     = 64,
    parameter int VALUE_BITS   = 32,
    parameter int MAX_DISTANCE = 127,
    parameter int IDX_W        = $clog2(SLOTS),
    parameter int CNT_W        = $clog2(SLOTS) + 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rht_cmd_t              cmd,
    output rht_stat_t             stat,
    input  logic [KIND_W-1:0]     kind,
    input  logic [31:0]           key_hash,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [CFG_W-1:0]      max_fill,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [STATUS_W-1:0]   status,
    output logic [IDX_W-1:0]      slot_index,
    output logic [VALUE_BITS-1:0] read_value,
    output logic [CNT_W-1:0]      entries
);

    localparam int D_W   = ((IDX_W > DIST_W) ? IDX_W : DIST_W) + 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef struct packed {
        logic                  used;
        logic [DIST_W-1:0]     distance;
        logic [31:0]           hash;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } slot_t;

    slot_t slot_mem [SLOTS];
    slot_t rdata_reg;
    slot_t wr_data;
    logic  [IDX_W-1:0] wr_addr;
    logic  [IDX_W-1:0] rd_addr;

    logic [KIND_W-1:0]     req_kind_reg;
    logic [31:0]           req_hash_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;
    logic [31:0]           car_hash_reg;
    logic [KEY_BITS-1:0]   car_key_reg;
    logic [VALUE_BITS-1:0] car_value_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      prev_reg;
    logic [IDX_W-1:0]      first_reg;
    logic                  have_first_reg;
    logic [D_W-1:0]        d_reg;
    logic [IDX_W-1:0]      step_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [IDX_W-1:0]      res_slot_reg;
    logic [VALUE_BITS-1:0] res_rv_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [IDX_W-1:0]      out_slot_reg;
    logic [VALUE_BITS-1:0] out_rv_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic [IDX_W-1:0] home;

    assign home    = cmd.load ? key_hash[IDX_W-1:0] : req_hash_reg[IDX_W-1:0];
    // slot count is a power of two, so the probe wraps by overflow
    assign rd_addr = cmd.start ? home : idx_reg + 1'b1;

    always_comb
    begin
        wr_data = rdata_reg;
        wr_addr = idx_reg;
        case (cmd.wr)
            WR_VALUE:
            begin
                wr_data.value = req_value_reg;
            end
            WR_CARRY:
            begin
                wr_data = '{used: 1'b1, distance: d_reg[DIST_W-1:0], hash: car_hash_reg,
                            key: car_key_reg, value: car_value_reg};
            end
            WR_SHIFT:
            begin
                wr_data.distance = rdata_reg.distance - 1'b1;
                wr_addr          = prev_reg;
            end
            WR_FREE:
            begin
                wr_data.used = 1'b0;
                wr_addr      = prev_reg;
            end
            WR_SWEEP:
            begin
                wr_data.used = 1'b0;
                wr_addr      = step_reg;
            end
            default:
            begin
                wr_data = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr != WR_NONE)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= slot_mem[rd_addr];
    end

    // probe walk, entry count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            prev_reg       <= '0;
            d_reg          <= '0;
            step_reg       <= '0;
            have_first_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg  <= rd_addr;
                d_reg    <= '0;
                step_reg <= '0;
            end
            else if (cmd.advance)
            begin
                idx_reg  <= rd_addr;
                prev_reg <= idx_reg;
                step_reg <= step_reg + 1'b1;
                d_reg    <= (cmd.rebase ? D_W'(rdata_reg.distance) : d_reg) + 1'b1;
            end
            if (cmd.load)
            begin
                have_first_reg <= 1'b0;
            end
            else if (cmd.take)
            begin
                have_first_reg <= 1'b1;
            end
            case (cmd.cnt)
                CNT_INC: count_reg <= count_reg + 1'b1;
                CNT_DEC: count_reg <= count_reg - 1'b1;
                CNT_CLR: count_reg <= '0;
                default: count_reg <= count_reg;
            endcase
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_kind_reg  <= kind;
            req_hash_reg  <= key_hash;
            req_key_reg   <= key;
            req_value_reg <= value;
            car_hash_reg  <= key_hash;
            car_key_reg   <= key;
            car_value_reg <= value;
        end
        else if (cmd.take)
        begin
            car_hash_reg  <= rdata_reg.hash;
            car_key_reg   <= rdata_reg.key;
            car_value_reg <= rdata_reg.value;
        end
        if (cmd.take && !have_first_reg)
        begin
            first_reg <= idx_reg;
        end
        if (cmd.res_en)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_src)
                SRC_HIT_OLD:
                begin
                    res_slot_reg <= idx_reg;
                    res_rv_reg   <= rdata_reg.value;
                end
                SRC_HIT_NEW:
                begin
                    res_slot_reg <= idx_reg;
                    res_rv_reg   <= req_value_reg;
                end
                SRC_INSERT:
                begin
                    res_slot_reg <= have_first_reg ? first_reg : idx_reg;
                    res_rv_reg   <= req_value_reg;
                end
                default:
                begin
                    res_slot_reg <= '0;
                    res_rv_reg   <= '0;
                end
            endcase
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_rv_reg     <= res_rv_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.kind      = req_kind_reg;
    assign stat.used      = rdata_reg.used;
    assign stat.match     = (rdata_reg.hash == req_hash_reg) && (rdata_reg.key == req_key_reg);
    assign stat.d_gt      = d_reg > D_W'(rdata_reg.distance);
    assign stat.d_gt_max  = d_reg > D_W'(MAX_DISTANCE);
    assign stat.dist_zero = (rdata_reg.distance == '0);
    assign stat.step_last = &step_reg;
    assign stat.full      = (CMP_W'(count_reg) >= CMP_W'(max_fill))
                            || (CMP_W'(count_reg) >= CMP_W'(SLOTS));
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_index = out_slot_reg;
    assign read_value = out_rv_reg;
    assign entries    = out_count_reg;

endmodule

// ----- test/robin_hood_hash_table_tb.sv -----
`timescale 1ns / 100ps

module robin_hood_hash_table_tb;
    import rht_pkg::*;

    localparam int SLOTS    = 1024;
    localparam int MAX_DIST = 127;

    // one expected response of the table
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [9:0]          slot_index;
        logic [31:0]         read_value;
        logic [10:0]         entries;
    } rht_resp_t;

    // Shadow copy of the table plus the queue of pending responses.
    class rht_scoreboard;
        bit          used      [SLOTS];
        logic [6:0]  slot_dist [SLOTS];
        logic [31:0] hsh  [SLOTS];
        logic [63:0] k    [SLOTS];
        logic [31:0] val  [SLOTS];
        int unsigned count;
        int unsigned max_fill;
        rht_resp_t   pending[$];
        int          mismatches;

        function void reset_table();
            foreach (used[i]) used[i] = 0;
            count    = 0;
            max_fill = MAX_FILL_RESET;
        endfunction

        function int lookup(logic [31:0] h, logic [63:0] kk);
            int unsigned i;
            int unsigned d;
            i = h % SLOTS;
            d = 0;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!used[i] || d > slot_dist[i]) return -1;
                if (hsh[i] == h && k[i] == kk) return i;
                d++;
                i = (i + 1) % SLOTS;
            end
            return -1;
        endfunction

        // dry run of the displacement chain
        function bit chain_fits(logic [31:0] h);
            int unsigned i;
            int unsigned d;
            i = h % SLOTS;
            d = 0;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!used[i]) return d <= MAX_DIST;
                if (d > slot_dist[i])
                begin
                    if (d > MAX_DIST) return 0;
                    d = slot_dist[i];
                end
                d++;
                i = (i + 1) % SLOTS;
            end
            return 0;
        endfunction

        function int unsigned place_new(logic [31:0] h, logic [63:0] kk, logic [31:0] v);
            int unsigned i;
            int unsigned d;
            int unsigned first;
            bit          have_first;
            logic [6:0]  td;
            logic [31:0] th;
            logic [63:0] tk;
            logic [31:0] tv;
            i = h % SLOTS;
            d = 0;
            first = 0;
            have_first = 0;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!used[i])
                begin
                    used[i] = 1; slot_dist[i] = 7'(d); hsh[i] = h; k[i] = kk; val[i] = v;
                    count++;
                    return have_first ? first : i;
                end
                if (d > slot_dist[i])
                begin
                    td = slot_dist[i]; th = hsh[i]; tk = k[i]; tv = val[i];
                    if (!have_first)
                    begin
                        first = i;
                        have_first = 1;
                    end
                    slot_dist[i] = 7'(d); hsh[i] = h; k[i] = kk; val[i] = v;
                    d = td; h = th; kk = tk; v = tv;
                end
                d++;
                i = (i + 1) % SLOTS;
            end
            return first;
        endfunction

        function void shift_out(int unsigned i);
            int unsigned j;
            for (int n = 0; n < SLOTS; n++)
            begin
                j = (i + 1) % SLOTS;
                if (!used[j] || slot_dist[j] == 0) break;
                hsh[i] = hsh[j]; k[i] = k[j]; val[i] = val[j];
                slot_dist[i] = 7'(slot_dist[j] - 1);
                i = j;
            end
            used[i] = 0;
            if (count > 0) count--;
        endfunction

        // note one accepted request and queue its response
        function void note_request(logic [2:0] kd, logic [31:0] h, logic [63:0] kk,
                                   logic [31:0] v);
            rht_resp_t r;
            int        at;
            r.status = ST_NOT_FOUND;
            r.slot_index = 0;
            r.read_value = 0;
            if (kd == KIND_INSERT || kd == KIND_REPLACE)
            begin
                at = lookup(h, kk);
                if (at >= 0)
                begin
                    r.slot_index = 10'(at);
                    if (kd == KIND_REPLACE)
                    begin
                        val[at] = v;
                        r.status = ST_REPLACED;
                    end
                    else
                        r.status = ST_PRESENT;
                    r.read_value = val[at];
                end
                else if (count >= max_fill || count >= SLOTS || !chain_fits(h))
                    r.status = ST_FULL;
                else
                begin
                    r.slot_index = 10'(place_new(h, kk, v));
                    r.status = ST_INSERTED;
                    r.read_value = v;
                end
            end
            else if (kd == KIND_FIND || kd == KIND_REMOVE)
            begin
                at = lookup(h, kk);
                if (at >= 0)
                begin
                    r.slot_index = 10'(at);
                    r.read_value = val[at];
                    r.status = (kd == KIND_FIND) ? ST_FOUND : ST_REMOVED;
                    if (kd == KIND_REMOVE) shift_out(at);
                end
            end
            else if (kd == KIND_CLEAR)
            begin
                foreach (used[i]) used[i] = 0;
                count = 0;
                r.status = ST_CLEARED;
            end
            r.entries = 11'(count);
            pending.push_back(r);
        endfunction

        function void check_response(rht_resp_t got);
            rht_resp_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d slot %0d", got.status,
                             got.slot_index);
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.slot_index !== exp.slot_index ||
                got.read_value !== exp.read_value || got.entries !== exp.entries)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d %0d %h %0d, got %0d %0d %h %0d",
                             exp.status, exp.slot_index, exp.read_value, exp.entries,
                             got.status, got.slot_index, got.read_value, got.entries);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  kind;
    logic [31:0] key_hash;
    logic [63:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [31:0] read_value;
    logic [10:0] entries;

    rht_scoreboard sb;
    bit            stall_on;

    robin_hood_hash_table u_top (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Monitor: request transfers feed the shadow table, response transfers are checked.
    always @(posedge clk)
    begin
        rht_resp_t got;
        if (rst_n && in_valid && in_ready)
            sb.note_request(kind, key_hash, key, value);
        if (rst_n && out_valid && out_ready)
        begin
            got.status = status;
            got.slot_index = slot_index;
            got.read_value = read_value;
            got.entries = entries;
            sb.check_response(got);
        end
    end

    // Response-side backpressure: alternating stall / free-run stretches.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
        out_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // called at a falling edge; returns at a falling edge after the transfer
    task automatic send(logic [2:0] kd, logic [31:0] h, logic [63:0] kk, logic [31:0] v);
        in_valid = 1; kind = kd; key_hash = h; key = kk; value = v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (SLOTS * 4) @(negedge clk);
    endtask

    // set the fill limit with the table quiet
    task automatic set_fill(int unsigned lim);
        drain();
        apb_write(3'd0, lim);
        sb.max_fill = lim;
    endtask

    // Keys mostly come from a small pool so hits, removes and replacements are common;
    // half the hashes cluster on four home slots to build long chains and wraps.
    logic [31:0] pool_hash [64];
    logic [63:0] pool_key  [64];

    task automatic random_ops(int n, int max_k);
        int          p;
        int unsigned r;
        logic [2:0]  kd;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
            r = $urandom_range(0, 99);
            if (r < 35)      kd = KIND_INSERT;
            else if (r < 50) kd = KIND_REPLACE;
            else if (r < 72) kd = KIND_FIND;
            else if (r < 97) kd = KIND_REMOVE;
            else if (r < 98) kd = KIND_CLEAR;
            else             kd = 3'($urandom_range(5, 7));
            p = $urandom_range(0, max_k);
            if ($urandom_range(0, 19) == 0)
                send(kd, $urandom(), {$urandom(), $urandom()}, $urandom());
            else
                send(kd, pool_hash[p], pool_key[p], $urandom());
        end
    endtask

    initial
    begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.reset_table();
        sb.mismatches = 0;
        stall_on = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; kind = 0; key_hash = 0; key = 0; value = 0;
        out_ready = 1;
        for (int i = 0; i < 64; i++)
        begin
            // half the pool shares home slots near the top to force wrap-around
            pool_hash[i] = (i < 32) ? {22'($urandom_range(0, 1023)), 10'd1020 + 10'(i % 4)}
                                    : $urandom();
            pool_key[i]  = {$urandom(), $urandom()};
        end
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: extremes of the fields and every kind
        send(KIND_FIND, 32'h0, 64'h0, 32'h0);
        send(KIND_REMOVE, 32'h0, 64'h0, 32'h0);
        send(KIND_INSERT, 32'h0, 64'h0, 32'h0);
        send(KIND_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        send(KIND_REPLACE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A);
        send(KIND_INSERT, 32'h0000_07FF, 64'h1, 32'h1); // same home, wraps to slot 0/1
        send(KIND_FIND, 32'h0000_07FF, 64'h1, 32'h0);
        send(KIND_FIND, 32'h0000_07FF, 64'h2, 32'h0);
        send(KIND_REMOVE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send(KIND_FIND, 32'h0000_07FF, 64'h1, 32'h0);
        send(3'd5, 32'h0, 64'h0, 32'h0);
        send(3'd7, 32'hFFFF_FFFF, 64'h0, 32'h0);
        send(KIND_CLEAR, 32'h0, 64'h0, 32'h0);
        send(KIND_FIND, 32'h0, 64'h0, 32'h0);

        // fill limit of zero: every new key is full
        set_fill(0);
        send(KIND_INSERT, 32'h5, 64'h5, 32'h5);
        // fill limit of one: second key refused, existing key still answered
        set_fill(1);
        send(KIND_INSERT, 32'h5, 64'h5, 32'h5);
        send(KIND_INSERT, 32'h6, 64'h6, 32'h6);
        send(KIND_REPLACE, 32'h5, 64'h5, 32'h9);
        send(KIND_INSERT, 32'h5, 64'h5, 32'h7);

        // chain beyond the maximum distance: many keys on one home slot
        set_fill(1024);
        for (int i = 0; i < 140; i++)
            send(KIND_INSERT, 32'h0000_0100, 64'(i), 32'(i));
        send(KIND_INSERT, 32'h0000_0101, 64'hBEEF, 32'h1);
        send(KIND_REMOVE, 32'h0000_0100, 64'd3, 32'h0);
        send(KIND_CLEAR, 32'h0, 64'h0, 32'h0);

        // random phases over several fill limits, wait-for-empty pause between them
        set_fill(1);
        random_ops(150, 63);
        set_fill(40);
        random_ops(450, 63);
        set_fill(870);
        random_ops(450, 63);
        set_fill(2047);
        random_ops(340, 15);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rht_pkg.sv
hdl/rht_ctrl.sv
hdl/rht_dp.sv
hdl/robin_hood_hash_table.sv
test/robin_hood_hash_table_tb.sv
